### sv/qpic_pkg.sv
// ----------------------------------------------------------------------------
// qpic_pkg
// shared constants and types of the quad pulse integrator and edge counter
// ----------------------------------------------------------------------------
`default_nettype none

package qpic_pkg;

	localparam int CHANNELS  = 4;
	localparam int NUM_LANES = 4;

	localparam int INTEG_W = 8;
	localparam int COUNT_W = 16;
	localparam int CHAN_W  = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 72;

	localparam logic [INTEG_W-1:0] ROOF_RESET   = 8'd100;
	localparam logic [INTEG_W-1:0] THRESH_RESET = 8'd30;

	typedef enum logic {
		FUNC_SAMPLE = 1'b0,
		FUNC_LOAD   = 1'b1
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROOF   = 8'd0,
		REG_THRESH = 8'd1
	} cfg_reg_t;

	typedef struct packed {
		logic               sample;
		logic               load;
		logic               pin;
		logic [COUNT_W-1:0] load_value;
	} lane_ctl_t;

endpackage

`default_nettype wire

### sv/qpic_lane.sv
// ----------------------------------------------------------------------------
// qpic_lane
// one channel: saturating integrator, level register and wrapping edge count
// ----------------------------------------------------------------------------
`default_nettype none

module qpic_lane
	import qpic_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lane_ctl_t          ctl,
	input  wire logic [INTEG_W-1:0] roof,
	input  wire logic [INTEG_W-1:0] thresh,
	output logic                    level_nxt,
	output logic                    rising_nxt,
	output logic [COUNT_W-1:0]      count_nxt
);

	logic [INTEG_W-1:0] integ_q;
	logic               last_q;
	logic [COUNT_W-1:0] count_q;
	logic [INTEG_W-1:0] integ_nxt;

	always_comb begin
		integ_nxt = integ_q;
		if (ctl.sample) begin
			if (ctl.pin) begin
				if (integ_q < roof) begin
					integ_nxt = integ_q + INTEG_W'(1);
				end
			end else if (integ_q != '0) begin
				integ_nxt = integ_q - INTEG_W'(1);
			end
		end
	end

	assign level_nxt  = (integ_nxt > thresh);
	assign rising_nxt = ctl.sample & ~last_q & level_nxt;

	always_comb begin
		if (ctl.load) begin
			count_nxt = ctl.load_value;
		end else begin
			count_nxt = count_q + COUNT_W'(rising_nxt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			last_q  <= 1'b0;
			count_q <= '0;
		end else begin
			integ_q <= integ_nxt;
			count_q <= count_nxt;
			if (ctl.sample) begin
				last_q <= level_nxt;
			end
		end
	end

endmodule

`default_nettype wire

### sv/quad_pulse_integrator_counter_top.sv
// ----------------------------------------------------------------------------
// quad_pulse_integrator_counter_top
// four-channel integrating debounce with rising-edge counters
// ----------------------------------------------------------------------------
// usage:
//   s_* channel takes one item per transfer: tuser is func (0 sample the pins,
//   1 load an edge count), tdata holds pins, channel and load_value.
//   m_* channel returns one item for every input item: levels, rising edges
//   and the edge count of every channel.
//   cfg_* writes integrator_roof (index 0) or level_threshold (index 1);
//   other indexes are dropped. cfg_ready is always high; write only while idle.
// path: an item passes the input register, then the lane update into the output
//   register, which drives m_tvalid; a stall can hold it in the input register.
// throughput: one item per cycle while m_tready stays high; the per-channel
//   update is a single saturating step and compare in front of the output register.
// reset: integrators, levels and counts clear, roof 100, threshold 30, input
//   and output registers empty.
// stall: when m_tready is low the result holds and one more item is taken
//   into the input register; then s_tready drops until the result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_pulse_integrator_counter_top
	import qpic_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// config write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // pins[3:0] channel[5:4] load_value[21:6]
	input  wire logic                  s_tuser,  // func[0]
	// result stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata   // levels[3:0] rising[7:4] count_ch0[23:8]
	                                             // count_ch1[39:24] count_ch2[55:40]
	                                             // count_ch3[71:56]
);

	logic [INTEG_W-1:0]   roof_q;
	logic [INTEG_W-1:0]   thresh_q;

	logic                 vld_s1;
	func_t                func_s1;
	logic [NUM_LANES-1:0] pins_s1;
	logic [CHAN_W-1:0]    chan_s1;
	logic [COUNT_W-1:0]   load_s1;

	logic                 out_vld_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic                 advance;
	logic [NUM_LANES-1:0] level_nxt;
	logic [NUM_LANES-1:0] rising_nxt;
	logic [COUNT_W-1:0]   count_nxt [NUM_LANES];

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roof_q   <= ROOF_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROOF:   roof_q   <= cfg_data;
				REG_THRESH: thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	assign advance  = vld_s1 & (~out_vld_q | m_tready);
	assign s_tready = ~vld_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= func_t'(s_tuser);
			pins_s1 <= s_tdata[3:0];
			chan_s1 <= s_tdata[5:4];
			load_s1 <= s_tdata[21:6];
		end
	end

	// channel lanes
	for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
		if (k < CHANNELS) begin : g_on
			lane_ctl_t ctl;

			assign ctl.sample     = advance & (func_s1 == FUNC_SAMPLE);
			assign ctl.load       = advance & (func_s1 == FUNC_LOAD)
			                        & (chan_s1 == CHAN_W'(k));
			assign ctl.pin        = pins_s1[k];
			assign ctl.load_value = load_s1;

			qpic_lane u_lane (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.roof       (roof_q),
				.thresh     (thresh_q),
				.level_nxt  (level_nxt[k]),
				.rising_nxt (rising_nxt[k]),
				.count_nxt  (count_nxt[k])
			);
		end else begin : g_off
			assign level_nxt[k]  = 1'b0;
			assign rising_nxt[k] = 1'b0;
			assign count_nxt[k]  = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {count_nxt[3], count_nxt[2], count_nxt[1], count_nxt[0],
			               rising_nxt, level_nxt};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// a rising edge always leaves its level high
	a_rise_has_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[7:4] & ~m_tdata[3:0]) == '0))
		else $error("rising edge reported without level");

	// a load item never reports edges
	a_load_no_rise: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && func_s1 == FUNC_LOAD) |=> (m_tdata[7:4] == '0))
		else $error("edge reported on load item");

	// an empty output stage never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_vld_q |-> s_tready)
		else $error("input stalled with empty output register");

	// every advanced item shows up at the output
	a_advance_valid: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("advanced item lost");

endmodule

`default_nettype wire
